// File: rtl/salru_pkg.sv
// Shared types and constants for the set-associative LRU cache lookup.
// No dependencies; the controller, datapath and top level import this package.
package salru_pkg;

  // Fixed field widths.
  localparam int ADDR_W = 64;
  localparam int TAG_W  = 64;
  localparam int CNT_W  = 32;
  localparam int OFS_W  = 5;
  localparam int IDX_W  = 2;
  localparam int OUT_W  = 2;
  localparam int FLD_W  = 2;

  // Configuration port geometry.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_OFFSET_BITS = 1'b0;
  localparam logic REG_INDEX_BITS  = 1'b1;
  localparam logic [OFS_W-1:0] OFS_RESET = 5'd4;
  localparam logic [IDX_W-1:0] IDX_RESET = 2'd2;

  // Outcome codes.
  localparam logic [OUT_W-1:0] OUTCOME_HIT   = 2'd0;
  localparam logic [OUT_W-1:0] OUTCOME_FILL  = 2'd1;
  localparam logic [OUT_W-1:0] OUTCOME_EVICT = 2'd2;

  // Default geometry.
  localparam int DEF_SETS = 4;
  localparam int DEF_WAYS = 4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // accept an address beat and read its set row
    logic clear;   // write the reset row at the clear address
    logic commit;  // resolve the lookup, write back and load the result
  } salru_cmd_t;

endpackage

// File: rtl/salru_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/salru_ctrl.sv
// Controller for the cache lookup: clearing pass, accept, lookup, result beat.
// Depends on salru_pkg for the command struct.
module salru_ctrl #(
  parameter int SETS = salru_pkg::DEF_SETS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output salru_pkg::salru_cmd_t                    cmd,
  output logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] clr_addr
);
  import salru_pkg::*;

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [SET_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             start, commit, clear;

  // Handshake and command decode.
  assign in_ready = (state_r == ST_IDLE);
  assign start    = in_valid && in_ready;
  assign clear    = (state_r == ST_CLEAR);
  assign commit   = (state_r == ST_LOOK) && (!out_valid_r || out_ready);

  assign cmd.start  = start;
  assign cmd.clear  = clear;
  assign cmd.commit = commit;
  assign clr_addr   = clr_cnt_r;
  assign out_valid  = out_valid_r;

  // Next-state logic.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = commit || (out_valid_r && !out_ready);
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SET_W'(SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/salru_dp.sv
// Datapath for the cache lookup: address split, set row store, tag compare,
// LRU rank update, saturating totals and the result register.
// Depends on salru_pkg and salru_ram.
module salru_dp #(
  parameter int SETS = salru_pkg::DEF_SETS,
  parameter int WAYS = salru_pkg::DEF_WAYS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  salru_pkg::salru_cmd_t                    cmd,
  input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] clr_addr,
  input  logic [salru_pkg::OFS_W-1:0]              cfg_offset_bits,
  input  logic [salru_pkg::IDX_W-1:0]              cfg_index_bits,
  input  logic [salru_pkg::ADDR_W-1:0]             in_address,
  output logic [salru_pkg::OUT_W-1:0]              out_outcome,
  output logic [salru_pkg::FLD_W-1:0]              out_set_used,
  output logic [salru_pkg::FLD_W-1:0]              out_way_used,
  output logic [salru_pkg::CNT_W-1:0]              out_hits_so_far,
  output logic [salru_pkg::CNT_W-1:0]              out_misses_so_far,
  output logic [salru_pkg::CNT_W-1:0]              out_evictions_so_far
);
  import salru_pkg::*;

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int MAX_IB = $clog2(SETS + 1) - 1;
  localparam int ROW_W  = WAYS * (TAG_W + 1 + WAY_W);
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Address split for the beat being accepted.
  logic [IDX_W-1:0]  ib_eff;
  logic [ADDR_W-1:0] idx_mask;
  logic [ADDR_W-1:0] set_full;
  logic [SET_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;
  logic [5:0]        tag_shift;

  always_comb begin
    ib_eff    = (32'(cfg_index_bits) > MAX_IB) ? IDX_W'(MAX_IB) : cfg_index_bits;
    idx_mask  = (ADDR_W'(1) << ib_eff) - ADDR_W'(1);
    set_full  = (in_address >> cfg_offset_bits) & idx_mask;
    in_set    = set_full[SET_W-1:0];
    tag_shift = 6'(cfg_offset_bits) + 6'(ib_eff);
    in_tag    = in_address >> tag_shift;
  end

  // Lookup registers captured at accept.
  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      set_r <= in_set;
      tag_r <= in_tag;
    end
  end

  // Set row store: ranks, valid bits and tags of all ways of a set.
  logic [ROW_W-1:0] rd_row, wr_row, clr_row, new_row;
  logic [SET_W-1:0] wr_addr;
  logic             wr_en;

  assign wr_en   = cmd.clear || cmd.commit;
  assign wr_addr = cmd.clear ? clr_addr : set_r;
  assign wr_row  = cmd.clear ? clr_row : new_row;

  salru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_row),
    .re    (cmd.start),
    .raddr (in_set),
    .rdata (rd_row)
  );

  // Reset row: all ways invalid, rank equal to way number.
  always_comb begin
    logic [WAYS-1:0][WAY_W-1:0] rk;
    for (int w = 0; w < WAYS; w++) begin
      rk[w] = WAY_W'(w);
    end
    clr_row = {rk, {WAYS{1'b0}}, {(WAYS * TAG_W){1'b0}}};
  end

  // Tag compare, way choice and rank update.
  logic [WAYS-1:0][TAG_W-1:0] row_tags, new_tags;
  logic [WAYS-1:0]            row_valid, new_valid;
  logic [WAYS-1:0][WAY_W-1:0] row_rank, new_rank;
  logic [WAY_W-1:0]           way;
  logic [OUT_W-1:0]           outcome;

  assign {row_rank, row_valid, row_tags} = rd_row;

  always_comb begin
    logic             hit, has_free;
    logic [WAY_W-1:0] hit_way, free_way, lru_way, r;
    hit      = 1'b0;
    has_free = 1'b0;
    hit_way  = '0;
    free_way = '0;
    lru_way  = '0;
    // Scan downward so the lowest-numbered way wins.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_valid[w] && (row_tags[w] == tag_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!row_valid[w]) begin
        has_free = 1'b1;
        free_way = WAY_W'(w);
      end
      if (row_rank[w] == '0) begin
        lru_way = WAY_W'(w);
      end
    end
    priority if (hit) begin
      way     = hit_way;
      outcome = OUTCOME_HIT;
    end else if (has_free) begin
      way     = free_way;
      outcome = OUTCOME_FILL;
    end else begin
      way     = lru_way;
      outcome = OUTCOME_EVICT;
    end
    // Fill the chosen way on a miss.
    new_tags  = row_tags;
    new_valid = row_valid;
    if (!hit) begin
      new_tags[way]  = tag_r;
      new_valid[way] = 1'b1;
    end
    // Promote the chosen way to most recently used.
    r = row_rank[way];
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == way) begin
        new_rank[w] = WAY_W'(WAYS - 1);
      end else if (row_rank[w] > r) begin
        new_rank[w] = row_rank[w] - 1'b1;
      end else begin
        new_rank[w] = row_rank[w];
      end
    end
    new_row = {new_rank, new_valid, new_tags};
  end

  // Saturating totals.
  logic [CNT_W-1:0] hit_total_r, miss_total_r, evict_total_r;
  logic [CNT_W-1:0] hit_total_nxt, miss_total_nxt, evict_total_nxt;

  always_comb begin
    hit_total_nxt   = hit_total_r;
    miss_total_nxt  = miss_total_r;
    evict_total_nxt = evict_total_r;
    if (outcome == OUTCOME_HIT) begin
      if (hit_total_r != CNT_MAX) hit_total_nxt = hit_total_r + 1'b1;
    end else begin
      if (miss_total_r != CNT_MAX) miss_total_nxt = miss_total_r + 1'b1;
      if ((outcome == OUTCOME_EVICT) && (evict_total_r != CNT_MAX)) begin
        evict_total_nxt = evict_total_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_total_r   <= '0;
      miss_total_r  <= '0;
      evict_total_r <= '0;
    end else if (cmd.commit) begin
      hit_total_r   <= hit_total_nxt;
      miss_total_r  <= miss_total_nxt;
      evict_total_r <= evict_total_nxt;
    end
  end

  // Result register; only the low bits of the set and way are reported.
  logic [31:0] set_ext, way_ext;
  assign set_ext = 32'(set_r);
  assign way_ext = 32'(way);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_outcome          <= outcome;
      out_set_used         <= set_ext[FLD_W-1:0];
      out_way_used         <= way_ext[FLD_W-1:0];
      out_hits_so_far      <= hit_total_nxt;
      out_misses_so_far    <= miss_total_nxt;
      out_evictions_so_far <= evict_total_nxt;
    end
  end

endmodule

// File: rtl/set_assoc_cache_lru_lookup.sv
// Top level of the set-associative cache lookup with LRU replacement.
// Depends on salru_pkg, salru_ctrl, salru_dp and salru_ram.
//
// Each address beat returns one result beat with the outcome (hit, fill of
// an invalid way, or eviction), the set and way used, and saturating hit,
// miss and eviction totals. The accept cycle reads the set's row (tags,
// valid bits and LRU ranks of all ways) from a RAM with a registered read
// port, and the lookup step that follows compares all ways in parallel,
// writes the updated row back and loads the result register; a new address
// is accepted only after that step, and a result not yet taken holds the
// lookup step of the next item. After reset a clearing pass writes every
// row to its reset value before the first address is accepted;
// configuration writes are taken at any time. Registers: offset_bits at
// byte address 0, index_bits at 4.
module set_assoc_cache_lru_lookup #(
  parameter int SETS = salru_pkg::DEF_SETS,
  parameter int WAYS = salru_pkg::DEF_WAYS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Address channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [salru_pkg::ADDR_W-1:0]       in_address,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [salru_pkg::OUT_W-1:0]        out_outcome,
  output logic [salru_pkg::FLD_W-1:0]        out_set_used,
  output logic [salru_pkg::FLD_W-1:0]        out_way_used,
  output logic [salru_pkg::CNT_W-1:0]        out_hits_so_far,
  output logic [salru_pkg::CNT_W-1:0]        out_misses_so_far,
  output logic [salru_pkg::CNT_W-1:0]        out_evictions_so_far,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [salru_pkg::CFG_AW-1:0]       paddr,
  input  logic [salru_pkg::CFG_DW-1:0]       pwdata,
  output logic [salru_pkg::CFG_DW-1:0]       prdata,
  output logic                               pready
);
  import salru_pkg::*;

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

  // Configuration registers.
  logic [OFS_W-1:0] offset_bits_r;
  logic [IDX_W-1:0] index_bits_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= OFS_RESET;
      index_bits_r  <= IDX_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_OFFSET_BITS: offset_bits_r <= pwdata[OFS_W-1:0];
        REG_INDEX_BITS:  index_bits_r  <= pwdata[IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      REG_OFFSET_BITS: prdata = CFG_DW'(offset_bits_r);
      REG_INDEX_BITS:  prdata = CFG_DW'(index_bits_r);
      default:         prdata = '0;
    endcase
  end

  // Controller and datapath.
  salru_cmd_t       cmd;
  logic [SET_W-1:0] clr_addr;

  salru_ctrl #(
    .SETS (SETS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .clr_addr  (clr_addr)
  );

  salru_dp #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .clr_addr             (clr_addr),
    .cfg_offset_bits      (offset_bits_r),
    .cfg_index_bits       (index_bits_r),
    .in_address           (in_address),
    .out_outcome          (out_outcome),
    .out_set_used         (out_set_used),
    .out_way_used         (out_way_used),
    .out_hits_so_far      (out_hits_so_far),
    .out_misses_so_far    (out_misses_so_far),
    .out_evictions_so_far (out_evictions_so_far)
  );

endmodule
